[src/charlier_polynomial_eval_unit_macros.svh]
// Assertion macros for the Charlier polynomial evaluator.
// Used by the port checker; no other dependencies.
`ifndef CHARLIER_POLYNOMIAL_EVAL_UNIT_MACROS_SVH
`define CHARLIER_POLYNOMIAL_EVAL_UNIT_MACROS_SVH

// Antecedent in a cycle implies consequent in the next, off during reset.
`define CPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpe port check failed");

// Consequent must hold in the cycle after reset is sampled low.
`define CPE_ASSERT_RESET(lbl, clk, rst_n, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("cpe reset check failed");

`endif

[src/cpe_pkg.sv]
// Shared widths, constants and helpers for the Charlier polynomial evaluator.
// No dependencies.
`timescale 1ns / 1ps

package cpe_pkg;

  // field widths
  localparam int X_W        = 32;  // arg_x, signed Q16.16
  localparam int N_W        = 8;   // degree, signed
  localparam int C_W        = 48;  // poly value, signed Q24.24
  localparam int MA_W       = 31;  // mean_a, unsigned Q15.16
  localparam int RC_W       = 32;  // recip_mean, unsigned Q8.24
  localparam int AMX_W      = 34;  // a - x and k + a - x, signed
  localparam int DIG_W      = 32;  // multiplier digit
  localparam int OPD_W      = 64;  // multiplier operand magnitude, two digits
  localparam int ACC_W      = 128; // product accumulator
  localparam int FRAC_X     = 16;  // fraction bits of Q16.16
  localparam int FRAC_C     = 24;  // fraction bits of Q24.24
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_A     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_MEAN = 8'd1;

  // register reset values
  localparam logic [MA_W-1:0] MEAN_A_RST = 31'd65536;
  localparam logic [RC_W-1:0] RECIP_RST  = 32'd16777216;

  // Q24.24 constants and clamp limits
  localparam logic signed [C_W-1:0] Q_ONE   = 48'sh0000_0100_0000;
  localparam logic signed [C_W-1:0] LIM_POS = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [C_W-1:0] LIM_NEG = 48'sh8000_0000_0000;

  // magnitude of a signed operand
  function automatic logic [OPD_W-1:0] mag64(input logic signed [OPD_W-1:0] v);
    logic signed [OPD_W-1:0] neg_v;
    neg_v = -v;
    return v[OPD_W-1] ? OPD_W'(neg_v) : OPD_W'(v);
  endfunction

endpackage

[src/charlier_polynomial_eval_unit.sv]
// Charlier polynomial evaluator, top level: sequencer plus one shared
// 32x32 multiplier with accumulator. Depends on cpe_pkg.
`timescale 1ns / 1ps

//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------------------
//  input   | in_arg_x, in_degree                     | start & !busy
//  result  | out_poly_value, out_overflow            | out_valid strobe, one cycle
//  config  | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//
// Negative or zero degree: result strobe in the cycle after the word is taken.
// Degree n >= 1: the result strobe follows the last recurrence step; each
// step runs the single 32x32 multiplier for eight partial products plus
// accumulate, rounding and setup states.
// busy is high for the whole evaluation. Synchronous active-low reset, no
// clearing pass. The result receiver cannot stall; cfg_ready is always high.

module charlier_polynomial_eval_unit
  import cpe_pkg::*;
#(
  parameter int MAX_DEGREE = 127
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [X_W-1:0]       in_arg_x,
  input  logic signed [N_W-1:0]       in_degree,
  output logic                        out_valid,
  output logic signed [C_W-1:0]       out_poly_value,
  output logic                        out_overflow,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int K_W  = $clog2(MAX_DEGREE + 1);
  localparam int KC_W = C_W + K_W;   // k * C[k-1], exact
  localparam int D_W  = KC_W + 1;    // p - k * C[k-1], exact

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_FIN,
    ST_STEP,
    ST_SETUP_DR
  } state_t;

  typedef enum logic [1:0] {
    OP_C1,   // (a - x) * recip
    OP_TC,   // t * C[k]
    OP_KC,   // k * C[k-1]
    OP_DR    // d * recip
  } op_t;

  state_t                  state_r;
  op_t                     op_r;
  logic [MA_W-1:0]         mean_a_r;
  logic [RC_W-1:0]         recip_r;
  logic signed [AMX_W-1:0] amx_r;
  logic [K_W-1:0]          n_r;
  logic [K_W-1:0]          k_r;
  logic signed [C_W-1:0]   c0_r;
  logic signed [C_W-1:0]   c1_r;
  logic signed [C_W-1:0]   p_r;
  logic signed [D_W-1:0]   d_r;
  logic [OPD_W-1:0]        a_mag_r;
  logic [OPD_W-1:0]        b_mag_r;
  logic [1:0]              pp_r;
  logic [1:0]              pp_last_r;
  logic                    neg_r;
  logic                    sh24_r;
  logic [2*DIG_W-1:0]      prod_r;
  logic [1:0]              prod_off_r;
  logic                    prod_v_r;
  logic [ACC_W-1:0]        acc_r;
  logic                    ovf_r;
  logic                    out_valid_r;
  logic signed [C_W-1:0]   out_poly_r;
  logic                    out_ovf_r;

  // multiplier digit select and product
  logic [DIG_W-1:0]   a_dig;
  logic [DIG_W-1:0]   b_dig;
  logic [2*DIG_W-1:0] mul_prod;

  assign a_dig    = pp_r[0] ? a_mag_r[OPD_W-1:DIG_W] : a_mag_r[DIG_W-1:0];
  assign b_dig    = pp_r[1] ? b_mag_r[OPD_W-1:DIG_W] : b_mag_r[DIG_W-1:0];
  assign mul_prod = a_dig * b_dig;

  // partial product aligned to its digit offset
  logic [ACC_W-1:0] acc_add;
  always_comb begin
    case (prod_off_r)
      2'd0:    acc_add = ACC_W'(prod_r);
      2'd1:    acc_add = ACC_W'(prod_r) << DIG_W;
      2'd2:    acc_add = ACC_W'(prod_r) << (2 * DIG_W);
      default: acc_add = '0;
    endcase
  end

  // floor rounding of the signed product, then clamp to Q24.24
  logic [ACC_W-1:0]      bias;
  logic [ACC_W-1:0]      rnd_sum;
  logic [ACC_W-1:0]      q;
  logic                  q_hi_nz;
  logic [C_W-1:0]        q_lo;
  logic signed [C_W-1:0] q_s;
  logic                  sat_hit;
  logic signed [C_W-1:0] sat_val;

  always_comb begin
    if (!neg_r) begin
      bias = '0;
    end else if (sh24_r) begin
      bias = ACC_W'({FRAC_C{1'b1}});
    end else begin
      bias = ACC_W'({FRAC_X{1'b1}});
    end
    rnd_sum = acc_r + bias;
    q       = sh24_r ? (rnd_sum >> FRAC_C) : (rnd_sum >> FRAC_X);
    q_hi_nz = |q[ACC_W-1:C_W];
    q_lo    = q[C_W-1:0];
    q_s     = signed'(q_lo);
    if (neg_r) begin
      sat_hit = q_hi_nz || (q_lo > C_W'(LIM_NEG));
      sat_val = sat_hit ? LIM_NEG : -q_s;
    end else begin
      sat_hit = q_hi_nz || q_lo[C_W-1];
      sat_val = sat_hit ? LIM_POS : q_s;
    end
  end

  // exact k * C[k-1] and the difference d
  logic signed [KC_W-1:0] kc_val;
  logic signed [D_W-1:0]  d_calc;

  always_comb begin
    kc_val = neg_r ? -signed'(acc_r[KC_W-1:0]) : signed'(acc_r[KC_W-1:0]);
    d_calc = D_W'(p_r) - D_W'(kc_val);
  end

  // operand preparation
  logic signed [AMX_W-1:0] amx_in;
  logic signed [AMX_W-1:0] t_val;
  logic [OPD_W-1:0]        amx_mag;
  logic [OPD_W-1:0]        t_mag;
  logic [OPD_W-1:0]        c0_mag;
  logic [OPD_W-1:0]        c1_mag;
  logic [OPD_W-1:0]        d_mag;
  logic [K_W-1:0]          n_in;

  always_comb begin
    amx_in  = AMX_W'(signed'({1'b0, mean_a_r})) - AMX_W'(in_arg_x);
    t_val   = AMX_W'(signed'({1'b0, k_r, {FRAC_X{1'b0}}})) + amx_r;
    amx_mag = mag64(OPD_W'(amx_in));
    t_mag   = mag64(OPD_W'(t_val));
    c0_mag  = mag64(OPD_W'(c0_r));
    c1_mag  = mag64(OPD_W'(c1_r));
    d_mag   = mag64(OPD_W'(d_r));
    n_in    = (int'(in_degree) > MAX_DEGREE) ? K_W'(MAX_DEGREE) : K_W'(in_degree);
  end

  // sequencer, multiplier pipeline and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_C1;
      mean_a_r    <= MEAN_A_RST;
      recip_r     <= RECIP_RST;
      prod_v_r    <= 1'b0;
      pp_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      // config writes
      if (cfg_valid) begin
        case (cfg_index)
          REG_MEAN_A:     mean_a_r <= cfg_data[MA_W-1:0];
          REG_RECIP_MEAN: recip_r  <= cfg_data[RC_W-1:0];
          default: ;
        endcase
      end

      // product register, then accumulate in the following cycle
      prod_v_r <= (state_r == ST_MUL);
      if (state_r == ST_MUL) begin
        prod_r     <= mul_prod;
        prod_off_r <= 2'(pp_r[0]) + 2'(pp_r[1]);
      end
      if (prod_v_r) begin
        acc_r <= acc_r + acc_add;
      end

      case (state_r)
        ST_IDLE: begin
          if (start) begin
            ovf_r <= 1'b0;
            if (in_degree[N_W-1]) begin
              out_poly_r  <= '0;
              out_ovf_r   <= 1'b0;
              out_valid_r <= 1'b1;
            end else if (in_degree == '0) begin
              out_poly_r  <= Q_ONE;
              out_ovf_r   <= 1'b0;
              out_valid_r <= 1'b1;
            end else begin
              amx_r     <= amx_in;
              n_r       <= n_in;
              k_r       <= K_W'(1);
              c0_r      <= Q_ONE;
              op_r      <= OP_C1;
              a_mag_r   <= amx_mag;
              b_mag_r   <= OPD_W'(recip_r);
              pp_r      <= '0;
              pp_last_r <= 2'd1;
              neg_r     <= amx_in[AMX_W-1];
              sh24_r    <= 1'b0;
              acc_r     <= '0;
              state_r   <= ST_MUL;
            end
          end
        end

        ST_MUL: begin
          pp_r <= pp_r + 2'd1;
          if (pp_r == pp_last_r) begin
            state_r <= ST_DRAIN;
          end
        end

        ST_DRAIN: begin
          state_r <= ST_FIN;
        end

        ST_FIN: begin
          case (op_r)
            OP_C1: begin
              ovf_r <= ovf_r | sat_hit;
              c1_r  <= sat_val;
              if (n_r == K_W'(1)) begin
                out_poly_r  <= sat_val;
                out_ovf_r   <= ovf_r | sat_hit;
                out_valid_r <= 1'b1;
                state_r     <= ST_IDLE;
              end else begin
                state_r <= ST_STEP;
              end
            end
            OP_TC: begin
              ovf_r     <= ovf_r | sat_hit;
              p_r       <= sat_val;
              op_r      <= OP_KC;
              a_mag_r   <= c0_mag;
              b_mag_r   <= OPD_W'(k_r);
              pp_r      <= '0;
              pp_last_r <= 2'd1;
              neg_r     <= c0_r[C_W-1];
              sh24_r    <= 1'b0;
              acc_r     <= '0;
              state_r   <= ST_MUL;
            end
            OP_KC: begin
              d_r     <= d_calc;
              state_r <= ST_SETUP_DR;
            end
            OP_DR: begin
              ovf_r <= ovf_r | sat_hit;
              c0_r  <= c1_r;
              c1_r  <= sat_val;
              k_r   <= k_r + K_W'(1);
              if ((k_r + K_W'(1)) == n_r) begin
                out_poly_r  <= sat_val;
                out_ovf_r   <= ovf_r | sat_hit;
                out_valid_r <= 1'b1;
                state_r     <= ST_IDLE;
              end else begin
                state_r <= ST_STEP;
              end
            end
            default: state_r <= ST_IDLE;
          endcase
        end

        // t * C[k]: four partial products
        ST_STEP: begin
          op_r      <= OP_TC;
          a_mag_r   <= c1_mag;
          b_mag_r   <= t_mag;
          pp_r      <= '0;
          pp_last_r <= 2'd3;
          neg_r     <= t_val[AMX_W-1] ^ c1_r[C_W-1];
          sh24_r    <= 1'b0;
          acc_r     <= '0;
          state_r   <= ST_MUL;
        end

        // d * recip, Q24.24 result
        ST_SETUP_DR: begin
          op_r      <= OP_DR;
          a_mag_r   <= d_mag;
          b_mag_r   <= OPD_W'(recip_r);
          pp_r      <= '0;
          pp_last_r <= 2'd1;
          neg_r     <= d_r[D_W-1];
          sh24_r    <= 1'b1;
          acc_r     <= '0;
          state_r   <= ST_MUL;
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_poly_value = out_poly_r;
  assign out_overflow   = out_ovf_r;

endmodule

[src/cpe_port_checker.sv]
// Port-level checker for the Charlier polynomial evaluator, with its bind.
// Depends on cpe_pkg and charlier_polynomial_eval_unit_macros.svh.
`timescale 1ns / 1ps
`include "charlier_polynomial_eval_unit_macros.svh"

module cpe_port_checker
  import cpe_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic signed [N_W-1:0] in_degree,
  input logic                  out_valid,
  input logic signed [C_W-1:0] out_poly_value,
  input logic                  out_overflow
);

  logic accept;
  assign accept = start && !busy;

  // reset leaves the block idle with no result pending
  `CPE_ASSERT_RESET(a_reset_idle, clk, rst_n, !busy && !out_valid)

  // negative degree answers zero in the next cycle
  `CPE_ASSERT_NEXT(a_neg_degree, clk, rst_n, accept && in_degree[N_W-1], out_valid && (out_poly_value == '0) && !out_overflow)

  // degree zero answers one in the next cycle
  `CPE_ASSERT_NEXT(a_zero_degree, clk, rst_n, accept && (in_degree == '0), out_valid && (out_poly_value == Q_ONE) && !out_overflow)

  // positive degree starts an evaluation with no early result
  `CPE_ASSERT_NEXT(a_pos_degree, clk, rst_n, accept && !in_degree[N_W-1] && (in_degree != '0), busy && !out_valid)

endmodule

bind charlier_polynomial_eval_unit cpe_port_checker u_cpe_port_checker (.*);

[tb/sv/charlier_polynomial_eval_unit_test.sv]
// Self-checking testbench for charlier_polynomial_eval_unit: directed and random words
// against a bit-exact fixed-point recurrence predictor. Depends on cpe_pkg and the RTL.
`timescale 1ns / 1ps

module charlier_polynomial_eval_unit_test;
  import cpe_pkg::*;

  localparam int MAX_DEG         = 127;
  localparam int PHASE_WORDS     = 60;
  localparam int SETTLE_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT  = 25000;

  // register indexes outside the map: writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_BEYOND = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 8'hFF;

  // directed words: argument and degree extremes, x equal to a, zero/negative degree
  localparam int EDGE_COUNT = 16;
  localparam logic signed [X_W-1:0] EDGE_X [EDGE_COUNT] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000,
    32'h0002_0000, 32'h0000_8000, 32'hFFF0_0000, 32'h0030_0000
  };
  localparam logic signed [N_W-1:0] EDGE_N [EDGE_COUNT] = '{
    8'sd0, -8'sd1, -8'sd128, 8'sd1, 8'sd2, 8'sd127, 8'sd1, 8'sd1,
    8'sd127, 8'sd127, 8'sd5, 8'sd3, 8'sd4, 8'sd12, 8'sd20, 8'sd64
  };

  typedef struct packed {
    logic signed [X_W-1:0] arg_x;
    logic signed [N_W-1:0] degree;
    logic signed [C_W-1:0] value;
    logic                  ovf;
  } poly_result_t;

  // Tracks register contents, predicts each word's polynomial value, checks results
  class poly_scoreboard;
    logic [MA_W-1:0] mean_a;
    logic [RC_W-1:0] recip;
    poly_result_t    pending_values[$];
    int unsigned     errors;

    function new();
      mean_a = MEAN_A_RST;
      recip  = RECIP_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_MEAN_A) begin
        mean_a = data[MA_W-1:0];
      end else if (idx == REG_RECIP_MEAN) begin
        recip = data[RC_W-1:0];
      end
    endfunction

    // floor(lhs * rhs / 2^shift), clamped to Q24.24
    function logic signed [63:0] scaled_product(input logic signed [63:0] lhs,
                                                 input logic signed [63:0] rhs,
                                                 input int unsigned shift,
                                                 inout bit ovf);
      logic signed [127:0] wl, wr, prod;
      wl = 128'(lhs);
      wr = 128'(rhs);
      prod = (wl * wr) >>> shift;
      if (prod > 128'sd140737488355327) begin
        ovf  = 1'b1;
        prod = 128'sd140737488355327;
      end else if (prod < -128'sd140737488355328) begin
        ovf  = 1'b1;
        prod = -128'sd140737488355328;
      end
      return prod[63:0];
    endfunction

    // three-term recurrence in fixed point
    function poly_result_t charlier_value(logic signed [X_W-1:0] x, logic signed [N_W-1:0] deg);
      poly_result_t res;
      int n;
      longint k;
      logic signed [63:0] amx, rc, c0, c1, t, p, d, nx;
      bit ovf;
      ovf = 1'b0;
      n = int'(deg);
      if (n > MAX_DEG) n = MAX_DEG;
      res.arg_x  = x;
      res.degree = deg;
      if (n < 0) begin
        res.value = '0;
      end else if (n == 0) begin
        res.value = Q_ONE;
      end else begin
        amx = $signed({33'd0, mean_a}) - 64'(x);
        rc  = $signed({32'd0, recip});
        c0  = 64'sd16777216;
        c1  = scaled_product(amx, rc, FRAC_X, ovf);
        for (k = 1; k < n; k++) begin
          t  = k * 64'sd65536 + amx;
          p  = scaled_product(t, c1, FRAC_X, ovf);
          d  = p - k * c0;
          nx = scaled_product(d, rc, FRAC_C, ovf);
          c0 = c1;
          c1 = nx;
        end
        res.value = c1[C_W-1:0];
      end
      res.ovf = ovf;
      return res;
    endfunction

    function void note_word(logic signed [X_W-1:0] x, logic signed [N_W-1:0] deg);
      pending_values.push_back(charlier_value(x, deg));
    endfunction

    function int outstanding();
      return pending_values.size();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic signed [C_W-1:0] value, logic ovf);
      poly_result_t want;
      if (pending_values.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h ovf=%b", value, ovf));
      end else begin
        want = pending_values.pop_front();
        if (value !== want.value)
          report_mismatch($sformatf("x=%h n=%0d poly_value got %h want %h",
                                    want.arg_x, want.degree, value, want.value));
        if (ovf !== want.ovf)
          report_mismatch($sformatf("x=%h n=%0d overflow got %b want %b",
                                    want.arg_x, want.degree, ovf, want.ovf));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic signed [X_W-1:0] in_arg_x = '0;
  logic signed [N_W-1:0] in_degree = '0;
  logic                  out_valid;
  logic signed [C_W-1:0] out_poly_value;
  logic                  out_overflow;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  poly_scoreboard sb = new();
  int unsigned    idle_cycles = 0;

  charlier_polynomial_eval_unit #(.MAX_DEGREE(MAX_DEG)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_arg_x       (in_arg_x),
    .in_degree      (in_degree),
    .out_valid      (out_valid),
    .out_poly_value (out_poly_value),
    .out_overflow   (out_overflow),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // observe handshakes; results checked before a new word is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_word(out_poly_value, out_overflow);
      if (start && !busy) sb.note_word(in_arg_x, in_degree);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      // hang detection
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 == WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // hold start until the word is taken
  task automatic send_word(input logic signed [X_W-1:0] x, input logic signed [N_W-1:0] deg);
    start     <= 1'b1;
    in_arg_x  <= x;
    in_degree <= deg;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random word: mostly small degrees, a few long evaluations
  task automatic pick_word(output logic signed [X_W-1:0] x, output logic signed [N_W-1:0] deg);
    int r;
    if ($urandom_range(0, 2) == 0) x = $urandom;
    else x = int'($urandom_range(0, 48 << 16)) - (24 << 16);
    r = $urandom_range(0, 99);
    if (r < 10)      deg = N_W'(-int'($urandom_range(1, 128)));
    else if (r < 18) deg = '0;
    else if (r < 85) deg = N_W'($urandom_range(1, 12));
    else if (r < 97) deg = N_W'($urandom_range(13, 60));
    else             deg = N_W'($urandom_range(61, 127));
  endtask

  // program a setting, then a burst-and-gap run of random words, then drain
  task automatic run_phase(input logic [MA_W-1:0] mean, input logic [RC_W-1:0] recip_val);
    logic signed [X_W-1:0] x;
    logic signed [N_W-1:0] deg;
    int burst_left, gap;
    logic [CFG_DATA_W-1:0] mean_word;
    mean_word = {1'($urandom_range(0, 1)), mean};
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_MEAN_A, mean_word);
      write_reg(REG_RECIP_MEAN, recip_val);
    end else begin
      write_reg(REG_RECIP_MEAN, recip_val);
      write_reg(REG_MEAN_A, mean_word);
    end
    // stray writes outside the map must not disturb either register
    write_reg($urandom_range(0, 1) ? REG_BEYOND : REG_TOP, $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
    burst_left = $urandom_range(1, 8);
    for (int i = 0; i < PHASE_WORDS; i++) begin
      pick_word(x, deg);
      send_word(x, deg);
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        if (gap != 0) hold_off(gap);
        burst_left = $urandom_range(1, 8);
      end
    end
    wait_for_results();
  endtask

  initial begin
    logic [MA_W-1:0] mean;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset register values
    for (int i = 0; i < EDGE_COUNT; i++) begin
      send_word(EDGE_X[i], EDGE_N[i]);
    end
    wait_for_results();

    // settings: nominal, both extremes, zero registers, typical means, random
    run_phase(31'd65536, 32'd16777216);
    run_phase(31'd1, 32'hFFFF_FFFF);
    run_phase(31'h7FFF_FFFF, 32'd1);
    run_phase(31'd0, 32'd0);
    run_phase(31'd163840, 32'd6710886);
    run_phase(31'd32768, 32'd33554432);
    mean = MA_W'($urandom_range(1 << 12, 1 << 22));
    run_phase(mean, 32'((64'd1 << 40) / mean));
    run_phase(31'($urandom), $urandom);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/cpe_pkg.sv
src/charlier_polynomial_eval_unit.sv
src/cpe_port_checker.sv
tb/sv/charlier_polynomial_eval_unit_test.sv
